FILE: design/dptq_pkg.sv
// ----------------------------------------------------------------------------
// Task queue package
// Shared widths, opcode and status codes, controller states and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dptq_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PRIO_WIDTH_DEF  = 16;

  // Fixed field widths of the channels
  localparam int OP_W     = 3;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 16;
  localparam int PRIO_IO_W = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_CLEAR  = 3'd4
  } dptq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK    = 2'd0,
    RS_EMPTY = 2'd1,
    RS_FULL  = 2'd2
  } dptq_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD_WAIT,
    S_AGE,
    S_SORT_RD,
    S_KEY,
    S_CMP,
    S_PLACE,
    S_FINISH
  } dptq_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the accepted word, clear the result
    logic push_write;  // write the new task at the tail
    logic set_full;    // report full on push
    logic set_empty;   // report empty on pop or peek
    logic clear_q;     // drop every task
    logic head_read;   // read the head entry
    logic head_load;   // copy the head entry into the result
    logic head_pop;    // advance the head
    logic age_start;   // begin the aging pass at entry 0
    logic age_step;    // write back one aged entry, read the next
    logic sort_begin;  // start the insertion sort at entry 1
    logic sort_read;   // read the entry to insert
    logic key_load;    // hold it as the key, read its left neighbor
    logic cmp_shift;   // move the neighbor one place right, read the next
    logic place;       // write the key into its slot
    logic out_load;    // move the result into the output register
  } dptq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            empty;
    logic            multi;      // two or more tasks held
    logic            last;       // index is on the last held task
    logic            prio_gt;    // neighbor priority above the key
    logic            j_one;      // insert position is at entry 1
    logic            out_stall;  // output word still waiting
  } dptq_sts_t;

endpackage

FILE: design/dptq_in_if.sv
// ----------------------------------------------------------------------------
// Task queue request channel
// Valid/ready channel that carries one queue operation per word.
// ----------------------------------------------------------------------------
interface dptq_in_if;
  logic                            valid;
  logic                            ready;
  logic [dptq_pkg::OP_W-1:0]       opcode;
  logic [dptq_pkg::ID_W-1:0]       task_id;
  logic [dptq_pkg::PRIO_IO_W-1:0]  task_priority;
  logic [dptq_pkg::TIME_W-1:0]     exec_time;
  logic [dptq_pkg::TIME_W-1:0]     time_left;
  logic [dptq_pkg::TIME_W-1:0]     now;

  modport source (output valid, opcode, task_id, task_priority, exec_time, time_left, now,
                  input ready);
  modport sink (input valid, opcode, task_id, task_priority, exec_time, time_left, now,
                output ready);
endinterface

FILE: design/dptq_out_if.sv
// ----------------------------------------------------------------------------
// Task queue response channel
// Valid/ready channel that carries one result word per operation.
// ----------------------------------------------------------------------------
interface dptq_out_if;
  logic                            valid;
  logic                            ready;
  logic [dptq_pkg::ID_W-1:0]       head_id;
  logic [dptq_pkg::PRIO_IO_W-1:0]  head_priority;
  logic [dptq_pkg::TIME_W-1:0]     head_exec_time;
  logic [dptq_pkg::TIME_W-1:0]     head_time_left;
  logic [dptq_pkg::STATUS_W-1:0]   status;
  logic [dptq_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, head_id, head_priority, head_exec_time, head_time_left,
                  status, occupancy, input ready);
  modport sink (input valid, head_id, head_priority, head_exec_time, head_time_left,
                status, occupancy, output ready);
endinterface

FILE: design/dptq_ctrl.sv
// ----------------------------------------------------------------------------
// Task queue controller
// Sequences each operation: push, pop, peek, clear, and the aging pass
// followed by a stable insertion sort over the task memory.
// ----------------------------------------------------------------------------
module dptq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dptq_pkg::dptq_sts_t sts,
  output dptq_pkg::dptq_cmd_t cmd
);

  dptq_pkg::dptq_state_t state;
  dptq_pkg::dptq_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dptq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == dptq_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      dptq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = dptq_pkg::S_EXEC;
        end
      end
      dptq_pkg::S_EXEC: begin
        state_next = dptq_pkg::S_FINISH;
        unique case (dptq_pkg::dptq_op_t'(sts.opcode)) inside
          dptq_pkg::OP_PUSH: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.push_write = 1'b1;
            end
          end
          dptq_pkg::OP_POP, dptq_pkg::OP_PEEK: begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
            end else begin
              cmd.head_read = 1'b1;
              state_next    = dptq_pkg::S_HEAD_WAIT;
            end
          end
          dptq_pkg::OP_UPDATE: begin
            if (!sts.empty) begin
              cmd.age_start = 1'b1;
              state_next    = dptq_pkg::S_AGE;
            end
          end
          dptq_pkg::OP_CLEAR: begin
            cmd.clear_q = 1'b1;
          end
          default: begin
          end
        endcase
      end
      dptq_pkg::S_HEAD_WAIT: begin
        cmd.head_load = 1'b1;
        cmd.head_pop  = (dptq_pkg::dptq_op_t'(sts.opcode) == dptq_pkg::OP_POP);
        state_next    = dptq_pkg::S_FINISH;
      end
      dptq_pkg::S_AGE: begin
        cmd.age_step = 1'b1;
        if (sts.last) begin
          if (sts.multi) begin
            cmd.sort_begin = 1'b1;
            state_next     = dptq_pkg::S_SORT_RD;
          end else begin
            state_next = dptq_pkg::S_FINISH;
          end
        end
      end
      dptq_pkg::S_SORT_RD: begin
        cmd.sort_read = 1'b1;
        state_next    = dptq_pkg::S_KEY;
      end
      dptq_pkg::S_KEY: begin
        cmd.key_load = 1'b1;
        state_next   = dptq_pkg::S_CMP;
      end
      dptq_pkg::S_CMP: begin
        // Shift larger neighbors right until the key fits
        if (sts.prio_gt) begin
          cmd.cmp_shift = 1'b1;
          if (sts.j_one) begin
            state_next = dptq_pkg::S_PLACE;
          end
        end else begin
          state_next = dptq_pkg::S_PLACE;
        end
      end
      dptq_pkg::S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.last ? dptq_pkg::S_FINISH : dptq_pkg::S_SORT_RD;
      end
      dptq_pkg::S_FINISH: begin
        if (!sts.out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = dptq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dptq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/dptq_datapath.sv
// ----------------------------------------------------------------------------
// Task queue datapath
// Circular task memory with head pointer and count, aging logic, sort
// indexes and key register, and the result and output registers.
// ----------------------------------------------------------------------------
module dptq_datapath #(
  parameter int QUEUE_DEPTH = dptq_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIO_WIDTH  = dptq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dptq_pkg::dptq_cmd_t              cmd,
  output dptq_pkg::dptq_sts_t              sts,
  input  logic [dptq_pkg::OP_W-1:0]        opcode,
  input  logic [dptq_pkg::ID_W-1:0]        task_id,
  input  logic [dptq_pkg::PRIO_IO_W-1:0]   task_priority,
  input  logic [dptq_pkg::TIME_W-1:0]      exec_time,
  input  logic [dptq_pkg::TIME_W-1:0]      time_left,
  input  logic [dptq_pkg::TIME_W-1:0]      now,
  dptq_out_if.source                       rsp
);

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int PW    = PRIO_WIDTH;
  localparam int IW    = (PW > dptq_pkg::PRIO_IO_W) ? PW : dptq_pkg::PRIO_IO_W;
  localparam int TW    = dptq_pkg::TIME_W;
  localparam int IDW   = dptq_pkg::ID_W;
  localparam int REC_W = IDW + PW + 2 * TW;
  // Field offsets inside one record
  localparam int TL_LO = 0;
  localparam int EX_LO = TW;
  localparam int PR_LO = 2 * TW;
  localparam int ID_LO = 2 * TW + PW;

  localparam logic [PW-1:0] PRIO_MAX = {PW{1'b1}};

  // Map a position from the head to a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [REC_W-1:0] mem [QUEUE_DEPTH];
  logic [REC_W-1:0] rd_data;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [REC_W-1:0] wdata;
  logic             we;

  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [AW-1:0]    idx_i;
  logic [AW-1:0]    idx_j;
  logic [REC_W-1:0] key;
  logic [REC_W-1:0] rec_in;
  logic [dptq_pkg::OP_W-1:0] op_q;
  logic [TW-1:0]    now_q;

  logic [IDW-1:0]                  res_id;
  logic [dptq_pkg::PRIO_IO_W-1:0]  res_prio;
  logic [TW-1:0]                   res_exec;
  logic [TW-1:0]                   res_tl;
  dptq_pkg::dptq_status_t          res_status;

  logic                            out_valid;
  logic [IDW-1:0]                  out_id;
  logic [dptq_pkg::PRIO_IO_W-1:0]  out_prio;
  logic [TW-1:0]                   out_exec;
  logic [TW-1:0]                   out_tl;
  logic [dptq_pkg::STATUS_W-1:0]   out_status;
  logic [dptq_pkg::OCC_W-1:0]      out_occ;

  logic [PW-1:0]    in_prio_sat;
  logic [IW-1:0]    in_prio_ext;
  logic [PW-1:0]    rd_prio;
  logic [PW-1:0]    key_prio;
  logic [PW-1:0]    aged_prio;
  logic [REC_W-1:0] aged_rec;
  logic [CW-1:0]    i_inc;
  logic [IW-1:0]    rd_prio_ext;

  // Saturate the pushed priority to the stored width
  always_comb begin
    in_prio_ext = IW'(task_priority);
    if (in_prio_ext > IW'(PRIO_MAX)) begin
      in_prio_sat = PRIO_MAX;
    end else begin
      in_prio_sat = in_prio_ext[PW-1:0];
    end
  end

  assign rd_prio     = rd_data[PR_LO +: PW];
  assign key_prio    = key[PR_LO +: PW];
  assign rd_prio_ext = IW'(rd_prio);
  assign i_inc       = CW'(idx_i) + CW'(1);

  // Age one entry: times four on exec time match, else times two on time left
  always_comb begin
    aged_prio = rd_prio;
    if (rd_data[EX_LO +: TW] == now_q) begin
      aged_prio = (|rd_prio[PW-1 -: 2]) ? PRIO_MAX : {rd_prio[PW-3:0], 2'b00};
    end else if (rd_data[TL_LO +: TW] == now_q) begin
      aged_prio = rd_prio[PW-1] ? PRIO_MAX : {rd_prio[PW-2:0], 1'b0};
    end
    aged_rec = rd_data;
    aged_rec[PR_LO +: PW] = aged_prio;
  end

  // Memory address and data selection
  always_comb begin
    raddr = phys(head, '0);
    waddr = phys(head, idx_i);
    wdata = aged_rec;
    we    = 1'b0;
    if (cmd.head_read) begin
      raddr = phys(head, '0);
    end
    if (cmd.age_step) begin
      raddr = phys(head, idx_i + AW'(1));
      we    = 1'b1;
    end
    if (cmd.sort_read) begin
      raddr = phys(head, idx_i);
    end
    if (cmd.key_load) begin
      raddr = phys(head, idx_i - AW'(1));
    end
    if (cmd.cmp_shift) begin
      raddr = phys(head, sts.j_one ? '0 : idx_j - AW'(2));
      waddr = phys(head, idx_j);
      wdata = rd_data;
      we    = 1'b1;
    end
    if (cmd.place) begin
      waddr = phys(head, idx_j);
      wdata = key;
      we    = 1'b1;
    end
    if (cmd.push_write) begin
      waddr = phys(head, AW'(count));
      wdata = rec_in;
      we    = 1'b1;
    end
  end

  // Task memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Head pointer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.clear_q) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push_write) begin
      count <= count + CW'(1);
    end else if (cmd.head_pop) begin
      head  <= phys(head, AW'(1));
      count <= count - CW'(1);
    end
  end

  // Captured word, sort indexes and key
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= opcode;
      now_q  <= now;
      rec_in <= {task_id, in_prio_sat, exec_time, time_left};
    end
    if (cmd.age_start) begin
      idx_i <= '0;
    end else if (cmd.sort_begin) begin
      idx_i <= AW'(1);
    end else if (cmd.age_step || cmd.place) begin
      idx_i <= idx_i + AW'(1);
    end
    if (cmd.key_load) begin
      key   <= rd_data;
      idx_j <= idx_i;
    end else if (cmd.cmp_shift) begin
      idx_j <= idx_j - AW'(1);
    end
  end

  // Result of the current operation
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_id     <= '0;
      res_prio   <= '0;
      res_exec   <= '0;
      res_tl     <= '0;
      res_status <= dptq_pkg::RS_OK;
    end else begin
      if (cmd.set_full) begin
        res_status <= dptq_pkg::RS_FULL;
      end
      if (cmd.set_empty) begin
        res_status <= dptq_pkg::RS_EMPTY;
      end
      if (cmd.head_load) begin
        res_id   <= rd_data[ID_LO +: IDW];
        res_prio <= rd_prio_ext[dptq_pkg::PRIO_IO_W-1:0];
        res_exec <= rd_data[EX_LO +: TW];
        res_tl   <= rd_data[TL_LO +: TW];
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id     <= res_id;
      out_prio   <= res_prio;
      out_exec   <= res_exec;
      out_tl     <= res_tl;
      out_status <= res_status;
      out_occ    <= dptq_pkg::OCC_W'(count);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.head_id        = out_id;
  assign rsp.head_priority  = out_prio;
  assign rsp.head_exec_time = out_exec;
  assign rsp.head_time_left = out_tl;
  assign rsp.status         = out_status;
  assign rsp.occupancy      = out_occ;

  // Status toward the controller
  always_comb begin
    sts.opcode    = op_q;
    sts.full      = (count == CW'(QUEUE_DEPTH));
    sts.empty     = (count == '0);
    sts.multi     = (count >= CW'(2));
    sts.last      = (i_inc == count);
    sts.prio_gt   = (rd_prio > key_prio);
    sts.j_one     = (idx_j == AW'(1));
    sts.out_stall = out_valid && !rsp.ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("task count above queue depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_write |-> (count < CW'(QUEUE_DEPTH)))
    else $error("push written into a full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.head_pop |=> (count == $past(count) - CW'(1)))
    else $error("pop did not drop the count by one");

  a_place_order: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> (idx_j <= idx_i))
    else $error("sort key placed right of its source");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !rsp.ready))
    else $error("result overwrote a waiting output word");
`endif

endmodule

FILE: design/dynamic_priority_task_queue_top.sv
// ----------------------------------------------------------------------------
// Task queue with priority aging
// Bounded task queue: push, pop, peek, clear, and an update that ages
// priorities against the current time and stably re-sorts by priority.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   opcode, task_id, task_priority, exec_time,
//                               time_left, now
//   rsp      out  valid/ready   head_id, head_priority, head_exec_time,
//                               head_time_left, status, occupancy
//
// Push, clear and the error cases load the output register in the finish
// step after exec; pop and peek pass a head-wait step first for the
// registered memory read. req is ready again once the controller is idle.
// Update ages each of the n tasks held, then inserts each entry in turn by
// read, key, compare-and-shift and place steps (moves total near n*n/2 at
// worst). A stalled rsp holds the next result in the finish step. Reset
// empties the queue at once; no memory sweep follows it.
// ----------------------------------------------------------------------------
module dynamic_priority_task_queue_top #(
  parameter int QUEUE_DEPTH = dptq_pkg::QUEUE_DEPTH_DEF,
  parameter int PRIO_WIDTH  = dptq_pkg::PRIO_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dptq_in_if.sink    req,
  dptq_out_if.source rsp
);

  dptq_pkg::dptq_cmd_t cmd;
  dptq_pkg::dptq_sts_t sts;
  logic                ready;

  // Operation sequencer
  dptq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign req.ready = ready;

  // Task memory and result path
  dptq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_WIDTH  (PRIO_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (req.opcode),
    .task_id       (req.task_id),
    .task_priority (req.task_priority),
    .exec_time     (req.exec_time),
    .time_left     (req.time_left),
    .now           (req.now),
    .rsp           (rsp)
  );

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Task queue with priority aging: testbench
// Drives push, pop, peek, update and clear words into the queue. A shadow
// copy of the task list computes the head fields, status and occupancy of
// every response, which is checked field by field in arrival order. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH = dptq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned PRIO_MAX = (1 << dptq_pkg::PRIO_WIDTH_DEF) - 1;
  localparam int RANDOM_OPS = 1520;

  typedef logic [dptq_pkg::OP_W-1:0]      opc_t;
  typedef logic [dptq_pkg::ID_W-1:0]      id_t;
  typedef logic [dptq_pkg::PRIO_IO_W-1:0] prio_t;
  typedef logic [dptq_pkg::TIME_W-1:0]    stamp_t;
  typedef logic [dptq_pkg::OCC_W-1:0]     occ_t;

  localparam opc_t OP_RSVD_FIRST = opc_t'(dptq_pkg::OP_CLEAR + 1);
  localparam opc_t OP_RSVD_LAST = '1;

  typedef struct packed {
    opc_t   opcode;
    id_t    id;
    prio_t  prio;
    stamp_t exec_t;
    stamp_t left_t;
    stamp_t now;
  } queue_cmd_t;

  typedef struct packed {
    id_t    id;
    prio_t  prio;
    stamp_t exec_t;
    stamp_t left_t;
  } task_rec_t;

  typedef struct packed {
    id_t                    id;
    prio_t                  prio;
    stamp_t                 exec_t;
    stamp_t                 left_t;
    dptq_pkg::dptq_status_t status;
    occ_t                   occ;
  } head_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dptq_in_if  req_if ();
  dptq_out_if rsp_if ();

  dynamic_priority_task_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #10 clk = ~clk;

  queue_cmd_t  op_words[$];      // words still to send
  task_rec_t   shadow_tasks[$];  // task list, head first
  head_word_t  result_words[$];  // responses owed, oldest first
  stamp_t      time_pool[$];     // recent exec and left times, for update hits

  int fails = 0;
  int cycles = 0;
  int n_push = 0, n_full = 0, n_take = 0, n_empty = 0, n_update = 0, n_clear = 0;
  int peak_occ = 0;
  int words_checked = 0;

  // Age every task against now, then rebuild the list stably by priority.
  function automatic void age_and_resort(input stamp_t now);
    task_rec_t ordered[$];
    int unsigned scaled;
    int k;
    foreach (shadow_tasks[i]) begin
      scaled = 32'(shadow_tasks[i].prio);
      if (shadow_tasks[i].exec_t == now) scaled = scaled * 4;
      else if (shadow_tasks[i].left_t == now) scaled = scaled * 2;
      shadow_tasks[i].prio = (scaled > PRIO_MAX) ? prio_t'(PRIO_MAX) : prio_t'(scaled);
    end
    foreach (shadow_tasks[i]) begin
      k = ordered.size();
      while (k > 0 && ordered[k-1].prio > shadow_tasks[i].prio) k--;
      ordered.insert(k, shadow_tasks[i]);
    end
    shadow_tasks = ordered;
  endfunction

  // Apply one accepted word to the shadow list and queue its response.
  function automatic void run_queue_op(input queue_cmd_t c);
    head_word_t w;
    task_rec_t t;
    w = '0;
    w.status = dptq_pkg::RS_OK;
    case (c.opcode) inside
      dptq_pkg::OP_PUSH: begin
        if (shadow_tasks.size() >= DEPTH) begin
          w.status = dptq_pkg::RS_FULL;
          n_full++;
        end else begin
          t.id = c.id;
          t.prio = (c.prio > PRIO_MAX) ? prio_t'(PRIO_MAX) : c.prio;
          t.exec_t = c.exec_t;
          t.left_t = c.left_t;
          shadow_tasks.push_back(t);
          n_push++;
        end
      end
      dptq_pkg::OP_POP, dptq_pkg::OP_PEEK: begin
        n_take++;
        if (shadow_tasks.size() == 0) begin
          w.status = dptq_pkg::RS_EMPTY;
          n_empty++;
        end else begin
          t = shadow_tasks[0];
          w.id = t.id;
          w.prio = t.prio;
          w.exec_t = t.exec_t;
          w.left_t = t.left_t;
          if (c.opcode == dptq_pkg::OP_POP) void'(shadow_tasks.pop_front());
        end
      end
      dptq_pkg::OP_UPDATE: begin
        age_and_resort(c.now);
        n_update++;
      end
      dptq_pkg::OP_CLEAR: begin
        shadow_tasks.delete();
        n_clear++;
      end
      default: ;
    endcase
    w.occ = occ_t'(shadow_tasks.size());
    if (shadow_tasks.size() > peak_occ) peak_occ = shadow_tasks.size();
    result_words.push_back(w);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // Time value: small values collide often, extremes now and then.
  function automatic stamp_t pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return stamp_t'($urandom_range(0, 15));
    if (r < 50) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return stamp_t'($urandom);
  endfunction

  function automatic prio_t pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return prio_t'($urandom_range(0, 7));
    if (r < 50) return prio_t'($urandom_range(16384, 65535));
    if (r < 60) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return prio_t'($urandom);
  endfunction

  function automatic void add_op(input opc_t opcode, input id_t id,
                                 input prio_t prio,
                                 input stamp_t exec_t,
                                 input stamp_t left_t,
                                 input stamp_t now);
    queue_cmd_t c;
    c.opcode = opcode;
    c.id = id;
    c.prio = prio;
    c.exec_t = exec_t;
    c.left_t = left_t;
    c.now = now;
    op_words.push_back(c);
    if (opcode == dptq_pkg::OP_PUSH) begin
      time_pool.push_back(exec_t);
      time_pool.push_back(left_t);
      while (time_pool.size() > 32) void'(time_pool.pop_front());
    end
  endfunction

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap();
    int r;
    if ((cycles / 500) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) cycles <= cycles + 1;

  // Request driver: hold the word until accepted, then idle or send the next.
  queue_cmd_t cur_cmd;
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) run_queue_op(cur_cmd);
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (op_words.size() != 0) begin
          cur_cmd = op_words.pop_front();
          req_if.opcode        <= cur_cmd.opcode;
          req_if.task_id       <= cur_cmd.id;
          req_if.task_priority <= cur_cmd.prio;
          req_if.exec_time     <= cur_cmd.exec_t;
          req_if.time_left     <= cur_cmd.left_t;
          req_if.now           <= cur_cmd.now;
          req_if.valid         <= 1'b1;
          send_gap = pick_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each accepted word, stall ready at random.
  head_word_t want;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_words.size() == 0) begin
          $display("%0t: response with none owed, status %0d occupancy %0d", $time,
                   rsp_if.status, rsp_if.occupancy);
          fails++;
        end else begin
          want = result_words.pop_front();
          check_field("head_id", 32'(want.id), 32'(rsp_if.head_id));
          check_field("head_priority", 32'(want.prio), 32'(rsp_if.head_priority));
          check_field("head_exec_time", 32'(want.exec_t), 32'(rsp_if.head_exec_time));
          check_field("head_time_left", 32'(want.left_t), 32'(rsp_if.head_time_left));
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("occupancy", 32'(want.occ), 32'(rsp_if.occupancy));
          words_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Stimulus, reset and end of run.
  int push_cut[4]   = '{65, 40, 20, 40};
  int pop_cut[4]    = '{80, 60, 65, 50};
  int peek_cut[4]   = '{87, 70, 75, 55};
  int update_cut[4] = '{96, 92, 93, 97};
  int clear_cut[4]  = '{98, 95, 96, 98};
  initial begin
    int mode;
    int r;
    opc_t opc;
    stamp_t now;

    // Empty queue: pop, peek, update, clear and the unused opcodes
    add_op(dptq_pkg::OP_POP, '1, '1, '1, '1, '1);
    add_op(dptq_pkg::OP_PEEK, '0, '0, '0, '0, '0);
    add_op(dptq_pkg::OP_UPDATE, '0, '0, '0, '0, 16'd500);
    for (int op = int'(OP_RSVD_FIRST); op <= int'(OP_RSVD_LAST); op++)
      add_op(opc_t'(op), id_t'($urandom), prio_t'($urandom), stamp_t'($urandom),
             stamp_t'($urandom), stamp_t'($urandom));
    add_op(dptq_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    // Fill to the brim: all-ones and all-zero tasks, then mixed ones, most of
    // whose exec or left time hits 500, some both, large priorities to saturate
    add_op(dptq_pkg::OP_PUSH, '1, '1, '1, '1, '0);
    add_op(dptq_pkg::OP_PUSH, '0, '0, '0, '0, '0);
    for (int i = 2; i < DEPTH; i++)
      add_op(dptq_pkg::OP_PUSH, id_t'(i),
             (i % 3 == 0) ? prio_t'(40000 + i) : prio_t'(i % 4),
             (i % 3 == 0) ? stamp_t'(500) : stamp_t'(i),
             (i % 3 != 2) ? stamp_t'(500) : stamp_t'(7000), '0);
    add_op(dptq_pkg::OP_PUSH, 8'h5a, 16'h1234, 16'h5678, 16'h9abc, '0);
    add_op(dptq_pkg::OP_UPDATE, '0, '0, '0, '0, 16'd500);
    add_op(dptq_pkg::OP_PEEK, '0, '0, '0, '0, '0);
    add_op(dptq_pkg::OP_UPDATE, '0, '0, '0, '0, '1);
    add_op(dptq_pkg::OP_POP, '0, '0, '0, '0, '0);
    add_op(dptq_pkg::OP_CLEAR, '0, '0, '0, '0, '0);

    // Random part: stretches that lean toward filling, draining or aging
    mode = 0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 3);
      r = $urandom_range(0, 99);
      if (r < push_cut[mode]) opc = dptq_pkg::OP_PUSH;
      else if (r < pop_cut[mode]) opc = dptq_pkg::OP_POP;
      else if (r < peek_cut[mode]) opc = dptq_pkg::OP_PEEK;
      else if (r < update_cut[mode]) opc = dptq_pkg::OP_UPDATE;
      else if (r < clear_cut[mode]) opc = dptq_pkg::OP_CLEAR;
      else opc = opc_t'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      r = $urandom_range(0, 99);
      if (r < 70 && time_pool.size() != 0)
        now = time_pool[$urandom_range(0, time_pool.size() - 1)];
      else if (r < 80) now = ($urandom_range(0, 1) != 0) ? '1 : '0;
      else now = stamp_t'($urandom);
      if (opc == dptq_pkg::OP_PUSH)
        add_op(opc, id_t'($urandom), pick_prio(), pick_time(), pick_time(), now);
      else
        add_op(opc, id_t'($urandom), prio_t'($urandom), stamp_t'($urandom),
               stamp_t'($urandom), now);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (op_words.size() != 0 || req_if.valid) @(posedge clk);
    while (result_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("checked %0d responses: %0d pushes stored, %0d refused as full, %0d pops/peeks",
             words_checked, n_push, n_full, n_take);
    $display("  (%0d on empty), %0d updates, %0d clears, peak occupancy %0d",
             n_empty, n_update, n_clear, peak_occ);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #60000000;
    $display("tb failed");
    $finish;
  end

endmodule
